// ===== design/sliding_template_match_min_ssd_unit_macros.svh =====
// Assertion macros shared by the sliding template matcher.
// Used by the top level; depends on nothing else.
`ifndef SLIDING_TEMPLATE_MATCH_MIN_SSD_UNIT_MACROS_SVH
`define SLIDING_TEMPLATE_MATCH_MIN_SSD_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define STM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Next-cycle implication, disabled during reset.
`define STM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define STM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define STM_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/sstm_pkg.sv =====
// Shared types and constants of the sliding template matcher.
// Depends on nothing; used by the top level, sstm_scan and sstm_accum.
package sstm_pkg;

   localparam int DIM_W  = 11;   // holds any clamped dimension up to 1024
   localparam int SUM_W  = 28;
   localparam int ACC_W  = 29;   // saturated sum plus one row of terms
   localparam int SQ_W   = 18;   // three squared channel differences
   localparam int PIX_W  = 24;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 8;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_TEMPLATE_W = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPLATE_H = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_W   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_H   = 4'd3;

   localparam logic OP_TEMPLATE = 1'b0;
   localparam logic OP_REGION   = 1'b1;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_RUN,
      SCAN_DRAIN
   } scan_state_type;

   // Marks that travel with one pixel pair through the pipeline.
   typedef struct packed {
      logic valid;
      logic row_end;
      logic win_end;
      logic last;
   } tag_type;

   // Sum of the squared red, green and blue differences of two pixels.
   function automatic logic [SQ_W-1:0] sq_diff3(input logic [PIX_W-1:0] p,
                                               input logic [PIX_W-1:0] q);
      logic signed [8:0]  d;
      logic signed [17:0] dd;
      logic [SQ_W-1:0]    acc;
      acc = '0;
      for (int c = 0; c < 3; c++) begin
         d = $signed({1'b0, p[c*8 +: 8]}) - $signed({1'b0, q[c*8 +: 8]});
         dd = d * d;
         acc = acc + SQ_W'(unsigned'(dd));
      end
      return acc;
   endfunction

endpackage

// ===== design/sliding_template_match_min_ssd_unit.sv =====
// Sliding template matcher, least sum of squared RGB differences. Pixels load
// one word per cycle into a template memory and a region memory. The word
// marked last starts a search over every window position where the template
// lies inside the region; it reads one template pixel per cycle, set by the
// single read port of each pixel memory, and its result word leaves through the
// datapath done register and the result register. A template that does not fit
// answers through the nofit and result registers with fits low and a zero sum.
// Input words are not taken during a search or while a result waits.
// Depends on sstm_pkg, sstm_mem, sstm_scan, sstm_accum and the macros header.
`include "sliding_template_match_min_ssd_unit_macros.svh"
module sliding_template_match_min_ssd_unit #(
   parameter int MAX_TEMPLATE_W = 32,
   parameter int MAX_TEMPLATE_H = 32,
   parameter int MAX_REGION_W   = 128,
   parameter int MAX_REGION_H   = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [sstm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sstm_pkg::CSR_DAT_W-1:0]    csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic [6:0]                        req_col,
   input  logic [6:0]                        req_row,
   input  logic [7:0]                        req_red,
   input  logic [7:0]                        req_green,
   input  logic [7:0]                        req_blue,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [27:0]                       rsp_min_ssd,
   output logic                              rsp_fits
);
   import sstm_pkg::*;

   localparam int T_DEPTH = MAX_TEMPLATE_W * MAX_TEMPLATE_H;
   localparam int R_DEPTH = MAX_REGION_W * MAX_REGION_H;
   localparam int TA_W    = (T_DEPTH > 1) ? $clog2(T_DEPTH) : 1;
   localparam int RA_W    = (R_DEPTH > 1) ? $clog2(R_DEPTH) : 1;

   logic [5:0]        tw_ff, th_ff;
   logic [7:0]        rw_ff, rh_ff;
   logic [DIM_W-1:0]  tw, th, rw, rh;
   logic              accept, start, busy, nofit, done;
   logic [PIX_W-1:0]  wr_pix, t_pix, r_pix;
   logic [TA_W-1:0]   t_wr_addr, t_rd_addr;
   logic [RA_W-1:0]   r_wr_addr, r_rd_addr;
   logic              t_wr_en, r_wr_en;
   tag_type           tag;
   logic [SUM_W-1:0]  best;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;
   logic              rsp_fits_ff, rsp_fits_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tw_ff <= 6'd1;
         th_ff <= 6'd1;
         rw_ff <= 8'd1;
         rh_ff <= 8'd1;
      end else if (csr_we) begin
         priority case (csr_index)
            CSR_TEMPLATE_W: tw_ff <= csr_wdata[5:0];
            CSR_TEMPLATE_H: th_ff <= csr_wdata[5:0];
            CSR_REGION_W:   rw_ff <= csr_wdata;
            CSR_REGION_H:   rh_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Dimensions saturated to the memory bounds.
   assign tw = (32'(tw_ff) > MAX_TEMPLATE_W) ? DIM_W'(MAX_TEMPLATE_W) : DIM_W'(tw_ff);
   assign th = (32'(th_ff) > MAX_TEMPLATE_H) ? DIM_W'(MAX_TEMPLATE_H) : DIM_W'(th_ff);
   assign rw = (32'(rw_ff) > MAX_REGION_W) ? DIM_W'(MAX_REGION_W) : DIM_W'(rw_ff);
   assign rh = (32'(rh_ff) > MAX_REGION_H) ? DIM_W'(MAX_REGION_H) : DIM_W'(rh_ff);

   // Input handshake and pixel writes; out-of-range pixels are dropped.
   // The cycle that carries a no-fit answer also holds off new words.
   assign req_ready = !busy && !rsp_valid_ff && !nofit;
   assign accept    = req_valid && req_ready;
   assign start     = accept && req_last;
   assign wr_pix    = {req_red, req_green, req_blue};
   assign t_wr_en   = accept && (req_op == OP_TEMPLATE)
                      && (32'(req_col) < MAX_TEMPLATE_W) && (32'(req_row) < MAX_TEMPLATE_H);
   assign r_wr_en   = accept && (req_op == OP_REGION)
                      && (32'(req_col) < MAX_REGION_W) && (32'(req_row) < MAX_REGION_H);
   assign t_wr_addr = TA_W'(32'(req_row) * MAX_TEMPLATE_W + 32'(req_col));
   assign r_wr_addr = RA_W'(32'(req_row) * MAX_REGION_W + 32'(req_col));

   sstm_mem #(.DEPTH(T_DEPTH), .WIDTH(PIX_W), .ADDR_W(TA_W)) u_template_mem (
      .clock   (clock),
      .wr_en   (t_wr_en),
      .wr_addr (t_wr_addr),
      .wr_data (wr_pix),
      .rd_addr (t_rd_addr),
      .rd_data (t_pix)
   );

   sstm_mem #(.DEPTH(R_DEPTH), .WIDTH(PIX_W), .ADDR_W(RA_W)) u_region_mem (
      .clock   (clock),
      .wr_en   (r_wr_en),
      .wr_addr (r_wr_addr),
      .wr_data (wr_pix),
      .rd_addr (r_rd_addr),
      .rd_data (r_pix)
   );

   sstm_scan #(
      .MAX_TEMPLATE_W (MAX_TEMPLATE_W),
      .MAX_REGION_W   (MAX_REGION_W),
      .TA_W           (TA_W),
      .RA_W           (RA_W)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .tw     (tw),
      .th     (th),
      .rw     (rw),
      .rh     (rh),
      .done   (done),
      .t_addr (t_rd_addr),
      .r_addr (r_rd_addr),
      .tag    (tag),
      .busy   (busy),
      .nofit  (nofit)
   );

   sstm_accum u_accum (
      .clock (clock),
      .reset (reset),
      .start (start),
      .tag   (tag),
      .t_pix (t_pix),
      .r_pix (r_pix),
      .best  (best),
      .done  (done)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_fits_in  = rsp_fits_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = best;
         rsp_fits_in  = 1'b1;
      end else if (nofit) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = '0;
         rsp_fits_in  = 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_sum_ff   <= '0;
         rsp_fits_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         rsp_sum_ff   <= rsp_sum_in;
         rsp_fits_ff  <= rsp_fits_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_min_ssd = rsp_sum_ff;
   assign rsp_fits    = rsp_fits_ff;

   // A search and a pending result both hold off new words.
   `STM_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, !busy && !rsp_valid)
   // A result without a fit carries a zero sum.
   `STM_ASSERT_IMP(a_nofit_zero, clock, reset, rsp_valid && !rsp_fits, rsp_min_ssd == '0)
   // A search start leaves the scan busy or reports no fit.
   `STM_ASSERT_NXT(a_start_busy, clock, reset, start, busy || nofit)
endmodule

// ===== design/sstm_mem.sv =====
// Single-port-write, single-port-read pixel memory with registered read data.
// Depends on nothing but its parameters.
module sstm_mem #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 24,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/sstm_scan.sv =====
// Window scan sequencer: walks every window position and template pixel.
// Depends on sstm_pkg; drives the read addresses of both pixel memories.
module sstm_scan #(
   parameter int MAX_TEMPLATE_W = 32,
   parameter int MAX_REGION_W   = 128,
   parameter int TA_W           = 10,
   parameter int RA_W           = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [sstm_pkg::DIM_W-1:0] tw,
   input  logic [sstm_pkg::DIM_W-1:0] th,
   input  logic [sstm_pkg::DIM_W-1:0] rw,
   input  logic [sstm_pkg::DIM_W-1:0] rh,
   input  logic                   done,
   output logic [TA_W-1:0]        t_addr,
   output logic [RA_W-1:0]        r_addr,
   output sstm_pkg::tag_type      tag,
   output logic                   busy,
   output logic                   nofit
);
   import sstm_pkg::*;

   scan_state_type    state_ff, state_in;
   logic [DIM_W-1:0]  x_ff, x_in, y_ff, y_in, dx_ff, dx_in, dy_ff, dy_in;
   tag_type           tag_ff, tag_in;
   logic              nofit_ff, nofit_in;
   logic              row_end, col_end, dx_end, dy_end, fits;

   // Fit check and end-of-range marks.
   assign fits    = (tw != '0) && (th != '0) && (tw <= rw) && (th <= rh);
   assign row_end = (x_ff == tw - 1'b1);
   assign col_end = (y_ff == th - 1'b1);
   assign dx_end  = (dx_ff == rw - tw);
   assign dy_end  = (dy_ff == rh - th);

   // Read addresses for the current pixel pair.
   assign t_addr = TA_W'(32'(y_ff) * MAX_TEMPLATE_W + 32'(x_ff));
   assign r_addr = RA_W'((32'(y_ff) + 32'(dy_ff)) * MAX_REGION_W
                         + 32'(x_ff) + 32'(dx_ff));

   // Next state and counter stepping.
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      tag_in   = '0;
      nofit_in = 1'b0;
      unique case (state_ff)
         SCAN_IDLE: begin
            x_in  = '0;
            y_in  = '0;
            dx_in = '0;
            dy_in = '0;
            if (start) begin
               if (fits) begin
                  state_in = SCAN_RUN;
               end else begin
                  nofit_in = 1'b1;
               end
            end
         end
         SCAN_RUN: begin
            tag_in.valid   = 1'b1;
            tag_in.row_end = row_end;
            tag_in.win_end = row_end && col_end;
            tag_in.last    = row_end && col_end && dx_end && dy_end;
            if (!row_end) begin
               x_in = x_ff + 1'b1;
            end else begin
               x_in = '0;
               if (!col_end) begin
                  y_in = y_ff + 1'b1;
               end else begin
                  y_in = '0;
                  if (!dx_end) begin
                     dx_in = dx_ff + 1'b1;
                  end else begin
                     dx_in = '0;
                     dy_in = dy_ff + 1'b1;
                     if (dy_end) begin
                        state_in = SCAN_DRAIN;
                     end
                  end
               end
            end
         end
         SCAN_DRAIN: begin
            if (done) begin
               state_in = SCAN_IDLE;
            end
         end
         default: state_in = SCAN_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_IDLE;
         tag_ff   <= '0;
         nofit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tag_ff   <= tag_in;
         nofit_ff <= nofit_in;
      end
   end

   // Counters.
   always_ff @(posedge clock) begin
      x_ff  <= x_in;
      y_ff  <= y_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
   end

   assign tag   = tag_ff;
   assign busy  = (state_ff != SCAN_IDLE);
   assign nofit = nofit_ff;
endmodule

// ===== design/sstm_accum.sv =====
// Squared-difference datapath: per-pixel terms, row saturation, window minimum.
// Depends on sstm_pkg; fed by the pixel memories and the scan tags.
module sstm_accum (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  sstm_pkg::tag_type            tag,
   input  logic [sstm_pkg::PIX_W-1:0]   t_pix,
   input  logic [sstm_pkg::PIX_W-1:0]   r_pix,
   output logic [sstm_pkg::SUM_W-1:0]   best,
   output logic                         done
);
   import sstm_pkg::*;

   tag_type           tag_a_ff;
   logic [SQ_W-1:0]   sq_a_ff;
   logic [ACC_W-1:0]  acc_ff, acc_in, acc_sum;
   logic [SUM_W-1:0]  best_ff, best_in, cand;
   logic              done_ff;

   // First stage: three squared channel differences.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
      end else begin
         tag_a_ff <= tag;
      end
      sq_a_ff <= sq_diff3(r_pix, t_pix);
   end

   // Second stage: running sum, saturated at each row end, minimum at window end.
   assign acc_sum = acc_ff + ACC_W'(sq_a_ff);
   assign cand    = (acc_sum > ACC_W'(SUM_MAX)) ? SUM_MAX : acc_sum[SUM_W-1:0];

   always_comb begin
      acc_in  = acc_ff;
      best_in = best_ff;
      if (start) begin
         acc_in  = '0;
         best_in = SUM_MAX;
      end else if (tag_a_ff.valid) begin
         if (tag_a_ff.win_end) begin
            acc_in = '0;
            if (cand < best_ff) begin
               best_in = cand;
            end
         end else if (tag_a_ff.row_end) begin
            acc_in = ACC_W'(cand);
         end else begin
            acc_in = acc_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         best_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         best_ff <= best_in;
         done_ff <= tag_a_ff.valid && tag_a_ff.last;
      end
   end

   assign best = best_ff;
   assign done = done_ff;
endmodule
